FILE: hdl/assert_macros.svh
// Assertion macros shared by the link reconnect controller RTL.
// Included by the core module, which carries the concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion on the block clock, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
   `ASSERT_CLK_RST(label, clock, reset, prop, msg)

`endif

FILE: hdl/lrb_pkg.sv
// Package for the link reconnect controller: event codes, link states, register indexes,
// and the context, configuration and result types. No dependencies.
`timescale 1ns / 1ps

package lrb_pkg;

   // Event codes carried by a request.
   localparam logic [2:0] ACT_OPEN         = 3'd0;
   localparam logic [2:0] ACT_CLOSE        = 3'd1;
   localparam logic [2:0] ACT_RECONNECT    = 3'd2;
   localparam logic [2:0] ACT_CONNECTED    = 3'd3;
   localparam logic [2:0] ACT_DISCONNECTED = 3'd4;
   localparam logic [2:0] ACT_FRAME        = 3'd5;
   localparam logic [2:0] ACT_TIMER        = 3'd6;

   // Link state codes.
   localparam logic [2:0] ST_DISCONNECTED = 3'd0;
   localparam logic [2:0] ST_CONNECTING   = 3'd1;
   localparam logic [2:0] ST_OPEN         = 3'd2;
   localparam logic [2:0] ST_RECONNECTING = 3'd3;
   localparam logic [2:0] ST_FAILED       = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_ATTEMPTS   = 2'd0;
   localparam logic [1:0] CSR_MAX_BACKOFF_MS = 2'd1;
   localparam logic [1:0] CSR_TRANSPORT      = 2'd2;

   // Register reset values.
   localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd10;
   localparam logic [15:0] MAX_BACKOFF_MS_RST = 16'd30000;

   // Backoff step per attempt in milliseconds, and the width of attempt times step.
   localparam int unsigned STEP_MS     = 1000;
   localparam int unsigned ATTEMPT_W   = 8;
   localparam int unsigned DELAY_W     = 16;
   localparam int unsigned PROD_W      = 18;
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

   // Persistent link context.
   typedef struct packed {
      logic [2:0]           state;
      logic                 watch_active;
      logic                 reopen_pending;
      logic [ATTEMPT_W-1:0] attempt_count;
      logic                 frame_seen;
   } lrb_ctx_type;

   // Configuration registers.
   typedef struct packed {
      logic [ATTEMPT_W-1:0] max_attempts;
      logic [DELAY_W-1:0]   max_backoff_ms;
      logic                 transport_available;
   } lrb_cfg_type;

   // Result of one request.
   typedef struct packed {
      logic [2:0]         link_state;
      logic [1:0]         state_changes;
      logic               open_link;
      logic               close_link;
      logic               timer_start;
      logic               timer_stop;
      logic [DELAY_W-1:0] delay_ms;
      logic               forward_frame;
   } lrb_rsp_type;

endpackage

FILE: hdl/lrb_next.sv
// Combinational event handler of the link reconnect controller: next context and result.
// Depends on lrb_pkg.
`timescale 1ns / 1ps

module lrb_next (
   input  lrb_pkg::lrb_ctx_type ctx_cur,
   input  lrb_pkg::lrb_cfg_type cfg,
   input  logic [2:0]           action,
   input  logic                 socket_busy,
   input  logic                 frame_valid,
   output lrb_pkg::lrb_ctx_type ctx_nxt,
   output lrb_pkg::lrb_rsp_type rsp
);
   import lrb_pkg::*;

   logic [ATTEMPT_W-1:0] att_inc;
   logic [PROD_W-1:0]    backoff_prod;
   logic [PROD_W-1:0]    backoff_cap;
   logic [DELAY_W-1:0]   backoff_ms;

   // Saturating attempt increment and capped linear backoff for the disconnect path.
   assign att_inc      = (ctx_cur.attempt_count == ATTEMPT_MAX) ? ATTEMPT_MAX
                       : ctx_cur.attempt_count + 1'b1;
   assign backoff_prod = PROD_W'(att_inc) * PROD_W'(STEP_MS);
   assign backoff_cap  = PROD_W'(cfg.max_backoff_ms);
   assign backoff_ms   = (backoff_prod > backoff_cap) ? cfg.max_backoff_ms
                       : backoff_prod[DELAY_W-1:0];

   // Event handling; each state move counts one notification when the state really changes.
   always_comb begin
      logic [2:0]           st;
      logic [1:0]           chg;
      logic [2:0]           open_st;
      lrb_ctx_type          c;
      lrb_rsp_type          r;

      c       = ctx_cur;
      r       = '0;
      st      = ctx_cur.state;
      chg     = 2'd0;
      open_st = ST_CONNECTING;

      unique case (action)
         ACT_OPEN: begin
            // Close first, then reopen from a clean attempt count.
            c.reopen_pending = 1'b0;
            r.timer_stop     = 1'b1;
            r.close_link     = 1'b1;
            chg = chg + {1'b0, st != ST_DISCONNECTED};
            st  = ST_DISCONNECTED;
            c.watch_active   = 1'b1;
            c.attempt_count  = '0;
            if (!cfg.transport_available) begin
               chg = chg + {1'b0, st != ST_FAILED};
               st  = ST_FAILED;
            end else begin
               if (socket_busy) begin
                  c.reopen_pending = 1'b1;
               end else begin
                  r.open_link = 1'b1;
               end
               chg = chg + {1'b0, st != ST_CONNECTING};
               st  = ST_CONNECTING;
            end
         end
         ACT_CLOSE: begin
            c.watch_active   = 1'b0;
            c.reopen_pending = 1'b0;
            r.timer_stop     = 1'b1;
            r.close_link     = 1'b1;
            chg = chg + {1'b0, st != ST_DISCONNECTED};
            st  = ST_DISCONNECTED;
         end
         ACT_RECONNECT: begin
            // Without a transport the request is ignored.
            if (cfg.transport_available) begin
               r.timer_stop    = 1'b1;
               r.close_link    = 1'b1;
               c.watch_active  = 1'b1;
               c.attempt_count = '0;
               if (socket_busy) begin
                  c.reopen_pending = 1'b1;
               end else begin
                  r.open_link = 1'b1;
               end
               chg = chg + {1'b0, st != ST_CONNECTING};
               st  = ST_CONNECTING;
            end
         end
         ACT_CONNECTED: begin
            c.frame_seen = 1'b0;
            chg = chg + {1'b0, st != ST_OPEN};
            st  = ST_OPEN;
         end
         ACT_DISCONNECTED: begin
            open_st = (ctx_cur.attempt_count != '0) ? ST_RECONNECTING : ST_CONNECTING;
            priority if (ctx_cur.reopen_pending) begin
               // Deferred reopen costs no attempt.
               c.reopen_pending = 1'b0;
               if (ctx_cur.watch_active) begin
                  r.open_link = 1'b1;
                  chg = chg + {1'b0, st != open_st};
                  st  = open_st;
               end
            end else if (!ctx_cur.watch_active) begin
               chg = chg + {1'b0, st != ST_DISCONNECTED};
               st  = ST_DISCONNECTED;
            end else begin
               c.attempt_count = att_inc;
               if (att_inc > cfg.max_attempts) begin
                  c.watch_active = 1'b0;
                  chg = chg + {1'b0, st != ST_FAILED};
                  st  = ST_FAILED;
               end else begin
                  r.timer_start = 1'b1;
                  r.delay_ms    = backoff_ms;
                  chg = chg + {1'b0, st != ST_RECONNECTING};
                  st  = ST_RECONNECTING;
               end
            end
         end
         ACT_FRAME: begin
            // A malformed frame is dropped; the first good one clears the attempt count.
            if (frame_valid) begin
               if (!ctx_cur.frame_seen) begin
                  c.frame_seen    = 1'b1;
                  c.attempt_count = '0;
               end
               r.forward_frame = 1'b1;
               chg = chg + {1'b0, st != ST_OPEN};
               st  = ST_OPEN;
            end
         end
         ACT_TIMER: begin
            if (ctx_cur.watch_active) begin
               open_st = (ctx_cur.attempt_count != '0) ? ST_RECONNECTING : ST_CONNECTING;
               r.open_link = 1'b1;
               chg = chg + {1'b0, st != open_st};
               st  = open_st;
            end
         end
         default: begin
            // Unused event code: report the state, change nothing.
         end
      endcase

      c.state         = st;
      r.link_state    = st;
      r.state_changes = chg;
      ctx_nxt         = c;
      rsp             = r;
   end

endmodule

FILE: hdl/link_reconnect_backoff_fsm_core.sv
// Top level of the link reconnect controller with capped linear backoff.
// Depends on lrb_pkg, lrb_next and assert_macros.svh.
`timescale 1ns / 1ps

// Reconnect controller for a watch link. Each request carries one event (open, close,
// reconnect now, connected, disconnected, frame, timer expired) and yields exactly one
// response with the new link state, the number of state changes, and the open, close,
// timer and forward commands. The block accepts one request per clock cycle while the
// response channel is not stalled. A response is registered: the request passes through
// the input register and the event logic into the response register, where it waits
// for rsp_ready. While a response is held off, one more request is taken
// into the input register, and req_ready then stays low until the response is accepted.
// Configuration registers are written through the csr_ port, which is always ready;
// write them only while no request is in flight.
module link_reconnect_backoff_fsm_core (
   input  logic        clock,
   input  logic        reset,
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic        req_socket_busy,
   input  logic        req_frame_valid,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_link_state,
   output logic [1:0]  rsp_state_changes,
   output logic        rsp_open_link,
   output logic        rsp_close_link,
   output logic        rsp_timer_start,
   output logic        rsp_timer_stop,
   output logic [15:0] rsp_delay_ms,
   output logic        rsp_forward_frame
);
   import lrb_pkg::*;

`include "assert_macros.svh"

   lrb_cfg_type cfg_ff, cfg_in;
   lrb_ctx_type ctx_ff, ctx_in, ctx_calc;
   lrb_rsp_type rsp_ff, rsp_calc;

   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_action_ff;
   logic       in_busy_ff;
   logic       in_fvalid_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;
   logic       advance;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS:   cfg_in.max_attempts        = csr_data[ATTEMPT_W-1:0];
            CSR_MAX_BACKOFF_MS: cfg_in.max_backoff_ms      = csr_data;
            CSR_TRANSPORT:      cfg_in.transport_available = csr_data[0];
            default: begin
               // Index beyond the register list: ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts        <= MAX_ATTEMPTS_RST;
         cfg_ff.max_backoff_ms      <= MAX_BACKOFF_MS_RST;
         cfg_ff.transport_available <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: the input register moves on when the response register is free.
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && rsp_free;
   assign req_ready    = !in_valid_ff || rsp_free;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_busy_ff   <= req_socket_busy;
         in_fvalid_ff <= req_frame_valid;
      end
   end

   // Event logic.
   lrb_next u_next (
      .ctx_cur     (ctx_ff),
      .cfg         (cfg_ff),
      .action      (in_action_ff),
      .socket_busy (in_busy_ff),
      .frame_valid (in_fvalid_ff),
      .ctx_nxt     (ctx_calc),
      .rsp         (rsp_calc)
   );

   // Link context is committed when the request moves into the response register.
   assign ctx_in = advance ? ctx_calc : ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else begin
         ctx_ff <= ctx_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_link_state    = rsp_ff.link_state;
   assign rsp_state_changes = rsp_ff.state_changes;
   assign rsp_open_link     = rsp_ff.open_link;
   assign rsp_close_link    = rsp_ff.close_link;
   assign rsp_timer_start   = rsp_ff.timer_start;
   assign rsp_timer_stop    = rsp_ff.timer_stop;
   assign rsp_delay_ms      = rsp_ff.delay_ms;
   assign rsp_forward_frame = rsp_ff.forward_frame;

   // A deferred reopen only exists while the watch is active.
   `ASSERT_CLK(a_pending_needs_active, ctx_ff.reopen_pending |-> ctx_ff.watch_active, "reopen pending while watch inactive")
   // The link state never leaves the defined codes.
   `ASSERT_CLK(a_state_range, ctx_ff.state <= ST_FAILED, "link state out of range")
   // Starting and cancelling the retry timer never come from the same event.
   `ASSERT_CLK(a_timer_excl, rsp_valid_ff |-> !(rsp_ff.timer_start && rsp_ff.timer_stop), "timer start and stop together")
   // A delay is reported only together with a timer start.
   `ASSERT_CLK(a_delay_zero, (rsp_valid_ff && !rsp_ff.timer_start) |-> (rsp_ff.delay_ms == '0), "delay without timer start")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for link_reconnect_backoff_fsm_core, the reconnect controller with capped backoff.
// Depends on lrb_pkg and the core RTL. It runs directed event sequences and then random
// event traffic, and checks each response against a predictor of its own.
`timescale 1ns / 1ps

module tb_top;
   import lrb_pkg::*;

   // Unassigned register index: writes to it must change nothing.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // Event code outside the defined set.
   localparam logic [2:0] ACT_UNUSED = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MAX_ATTEMPTS;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = ACT_OPEN;
   logic        req_socket_busy = 1'b0;
   logic        req_frame_valid = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [2:0]  rsp_link_state;
   logic [1:0]  rsp_state_changes;
   logic        rsp_open_link;
   logic        rsp_close_link;
   logic        rsp_timer_start;
   logic        rsp_timer_stop;
   logic [15:0] rsp_delay_ms;
   logic        rsp_forward_frame;

   link_reconnect_backoff_fsm_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_socket_busy   (req_socket_busy),
      .req_frame_valid   (req_frame_valid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_link_state    (rsp_link_state),
      .rsp_state_changes (rsp_state_changes),
      .rsp_open_link     (rsp_open_link),
      .rsp_close_link    (rsp_close_link),
      .rsp_timer_start   (rsp_timer_start),
      .rsp_timer_stop    (rsp_timer_stop),
      .rsp_delay_ms      (rsp_delay_ms),
      .rsp_forward_frame (rsp_forward_frame)
   );

   // Predicted link context and register contents, plus the response being built.
   lrb_ctx_type link_ctx = '0;
   lrb_cfg_type link_cfg = '{max_attempts: MAX_ATTEMPTS_RST,
                             max_backoff_ms: MAX_BACKOFF_MS_RST,
                             transport_available: 1'b1};
   lrb_rsp_type event_rsp;
   lrb_rsp_type pending_rsps[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          quiet_mode = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Moves the link to a new state and counts the change if there is one.
   function automatic void set_link(input logic [2:0] next_state);
      if (link_ctx.state != next_state) begin
         link_ctx.state = next_state;
         event_rsp.state_changes = event_rsp.state_changes + 2'd1;
      end
   endfunction

   // An open after a lost link reports reconnecting, a fresh one connecting.
   function automatic logic [2:0] opening_state();
      return (link_ctx.attempt_count != '0) ? ST_RECONNECTING : ST_CONNECTING;
   endfunction

   function automatic void begin_open();
      set_link(opening_state());
      event_rsp.open_link = 1'b1;
   endfunction

   // While the old socket is still closing, the open waits for its disconnect.
   function automatic void open_or_wait(input logic busy);
      if (busy) begin
         link_ctx.reopen_pending = 1'b1;
         set_link(opening_state());
      end else begin
         begin_open();
      end
   endfunction

   function automatic void drop_watch();
      link_ctx.watch_active = 1'b0;
      link_ctx.reopen_pending = 1'b0;
      event_rsp.timer_stop = 1'b1;
      event_rsp.close_link = 1'b1;
      set_link(ST_DISCONNECTED);
   endfunction

   // Disconnect: finish a deferred open, stay disconnected without a watch, or count an attempt and retry or fail.
   function automatic void link_lost();
      int unsigned wait_ms;
      if (link_ctx.reopen_pending) begin
         link_ctx.reopen_pending = 1'b0;
         if (link_ctx.watch_active)
            begin_open();
         return;
      end
      if (!link_ctx.watch_active) begin
         set_link(ST_DISCONNECTED);
         return;
      end
      if (link_ctx.attempt_count != ATTEMPT_MAX)
         link_ctx.attempt_count = link_ctx.attempt_count + 1'b1;
      if (link_ctx.attempt_count > link_cfg.max_attempts) begin
         link_ctx.watch_active = 1'b0;
         set_link(ST_FAILED);
         return;
      end
      wait_ms = link_ctx.attempt_count * STEP_MS;
      if (wait_ms > link_cfg.max_backoff_ms)
         wait_ms = 32'(link_cfg.max_backoff_ms);
      set_link(ST_RECONNECTING);
      event_rsp.timer_start = 1'b1;
      event_rsp.delay_ms = wait_ms[DELAY_W-1:0];
   endfunction

   // Applies one event to the predicted context and returns the expected response.
   function automatic lrb_rsp_type predict_event(input logic [2:0] act, input logic busy,
                                                 input logic frame_ok);
      event_rsp = '0;
      case (act)
         ACT_OPEN: begin
            drop_watch();
            link_ctx.watch_active = 1'b1;
            link_ctx.attempt_count = '0;
            if (!link_cfg.transport_available)
               set_link(ST_FAILED);
            else
               open_or_wait(busy);
         end
         ACT_CLOSE: drop_watch();
         ACT_RECONNECT: begin
            if (link_cfg.transport_available) begin
               event_rsp.timer_stop = 1'b1;
               link_ctx.watch_active = 1'b1;
               link_ctx.attempt_count = '0;
               event_rsp.close_link = 1'b1;
               open_or_wait(busy);
            end
         end
         ACT_CONNECTED: begin
            link_ctx.frame_seen = 1'b0;
            set_link(ST_OPEN);
         end
         ACT_DISCONNECTED: link_lost();
         ACT_FRAME: begin
            if (frame_ok) begin
               if (!link_ctx.frame_seen) begin
                  link_ctx.frame_seen = 1'b1;
                  link_ctx.attempt_count = '0;
               end
               set_link(ST_OPEN);
               event_rsp.forward_frame = 1'b1;
            end
         end
         ACT_TIMER: begin
            if (link_ctx.watch_active)
               begin_open();
         end
         default: ;
      endcase
      event_rsp.link_state = link_ctx.state;
      return event_rsp;
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [15:0] value);
      case (idx)
         CSR_MAX_ATTEMPTS:   link_cfg.max_attempts = value[ATTEMPT_W-1:0];
         CSR_MAX_BACKOFF_MS: link_cfg.max_backoff_ms = value;
         CSR_TRANSPORT:      link_cfg.transport_available = value[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   // Sends one request, sometimes after a random gap, and records its expected response.
   task automatic send_event(input logic [2:0] act, input logic busy, input logic frame_ok);
      int unsigned gap;
      gap = 0;
      if (!quiet_mode && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_socket_busy <= busy;
      req_frame_valid <= frame_ok;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(predict_event(act, busy, frame_ok));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops sending and lets every outstanding response drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers; the unused upper data bits carry noise.
   task automatic set_config(input logic [7:0] attempts, input logic [15:0] backoff,
                             input logic transport);
      logic [7:0]  junk_hi;
      logic [14:0] junk_tr;
      junk_hi = 8'($urandom_range(0, 255));
      junk_tr = 15'($urandom_range(0, 32767));
      wait_idle();
      write_csr(CSR_MAX_ATTEMPTS, {junk_hi, attempts});
      write_csr(CSR_MAX_BACKOFF_MS, backoff);
      write_csr(CSR_TRANSPORT, {junk_tr, transport});
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response-side stalls come in bursts of random length, except in reset and quiet mode.
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compares every accepted response with the oldest expected one.
   always @(posedge clock) begin
      lrb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual state %0d",
                     $time, rsp_link_state);
            mismatch_count++;
         end else begin
            want = pending_rsps.pop_front();
            check_field("link_state", 32'(want.link_state), 32'(rsp_link_state));
            check_field("state_changes", 32'(want.state_changes), 32'(rsp_state_changes));
            check_field("open_link", 32'(want.open_link), 32'(rsp_open_link));
            check_field("close_link", 32'(want.close_link), 32'(rsp_close_link));
            check_field("timer_start", 32'(want.timer_start), 32'(rsp_timer_start));
            check_field("timer_stop", 32'(want.timer_stop), 32'(rsp_timer_stop));
            check_field("delay_ms", 32'(want.delay_ms), 32'(rsp_delay_ms));
            check_field("forward_frame", 32'(want.forward_frame), 32'(rsp_forward_frame));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Events that must not disturb an idle controller, including the unused code.
   task automatic test_idle_events();
      send_event(ACT_UNUSED, 1'b1, 1'b1);
      send_event(ACT_TIMER, 1'b0, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_FRAME, 1'b0, 1'b0);
   endtask

   task automatic test_open_connect();
      send_event(ACT_OPEN, 1'b0, 1'b0);
      send_event(ACT_CONNECTED, 1'b0, 1'b0);
      send_event(ACT_FRAME, 1'b0, 1'b1);
      send_event(ACT_FRAME, 1'b1, 1'b1);
      send_event(ACT_CLOSE, 1'b0, 1'b0);
   endtask

   // Opens issued while the old socket is closing complete on its disconnect.
   task automatic test_deferred_open();
      send_event(ACT_OPEN, 1'b1, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_RECONNECT, 1'b1, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
   endtask

   // Linear delay up to the cap, then failure once the budget runs out.
   task automatic test_backoff_and_fail();
      set_config(8'd2, 16'd1500, 1'b1);
      send_event(ACT_OPEN, 1'b0, 1'b0);
      send_event(ACT_CONNECTED, 1'b0, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_TIMER, 1'b0, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_TIMER, 1'b0, 1'b0);
      send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_TIMER, 1'b0, 1'b0);
   endtask

   task automatic test_no_transport();
      set_config(MAX_ATTEMPTS_RST, MAX_BACKOFF_MS_RST, 1'b0);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_event(ACT_OPEN, 1'b0, 1'b0);
      send_event(ACT_RECONNECT, 1'b0, 1'b0);
   endtask

   // With the largest budget the counter must stop at its top value and never fail.
   task automatic test_attempt_saturation();
      set_config(8'd255, 16'hFFFF, 1'b1);
      send_event(ACT_OPEN, 1'b0, 1'b0);
      send_event(ACT_CONNECTED, 1'b0, 1'b0);
      repeat (260) send_event(ACT_DISCONNECTED, 1'b0, 1'b0);
      send_event(ACT_TIMER, 1'b0, 1'b0);
      send_event(ACT_CLOSE, 1'b0, 1'b0);
   endtask

   // Mostly plausible link life cycles picked from the current state, with some noise.
   task automatic send_random_event();
      logic [2:0]  act;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         act = 3'($urandom_range(0, 7));
      end else begin
         case (link_ctx.state)
            ST_DISCONNECTED, ST_FAILED:
               act = (pick < 70) ? ACT_OPEN : (pick < 88) ? ACT_RECONNECT : ACT_DISCONNECTED;
            ST_OPEN:
               act = (pick < 60) ? ACT_FRAME : (pick < 92) ? ACT_DISCONNECTED : ACT_CLOSE;
            default:
               act = (pick < 45) ? ACT_CONNECTED : (pick < 65) ? ACT_TIMER :
                     (pick < 90) ? ACT_DISCONNECTED : ACT_FRAME;
         endcase
      end
      send_event(act, $urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0);
   endtask

   task automatic test_random_traffic();
      set_config(8'd0, 16'hFFFF, 1'b1);
      repeat (110) send_random_event();
      set_config(8'd254, 16'd0, 1'b1);
      repeat (110) send_random_event();
      set_config(8'($urandom_range(1, 6)), 16'($urandom_range(0, 65535)), 1'b0);
      repeat (50) send_random_event();
      set_config(8'd255, 16'($urandom_range(1000, 9000)), 1'b1);
      repeat (100) send_random_event();
      set_config(8'($urandom_range(1, 20)), 16'($urandom_range(0, 40000)), 1'b1);
      quiet_mode = 1'b1;
      repeat (100) send_random_event();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_open_connect();
      test_deferred_open();
      test_backoff_and_fail();
      test_no_transport();
      test_attempt_saturation();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
